// ===== rtl/core/tevd_pkg.sv =====
// shared types, event codes and sizes for the touch event decoder
package tevd_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF     = 2;
	localparam int POS_W               = 16;
	localparam int STAMP_W             = 48;
	localparam int RAW_W               = 32;
	localparam int CFG_IDX_W           = 3;

	localparam logic [15:0] EV_TYPE_SYNC = 16'h0000;
	localparam logic [15:0] EV_TYPE_ABS  = 16'h0003;
	localparam logic [15:0] CODE_REPORT  = 16'h0000;
	localparam logic [15:0] CODE_SLOT    = 16'h002f;
	localparam logic [15:0] CODE_TRACK   = 16'h0039;
	localparam logic [15:0] CODE_POS_X   = 16'h0035;
	localparam logic [15:0] CODE_POS_Y   = 16'h0036;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y = 3'd5;

	typedef enum logic [1:0] {
		PHASE_DOWN = 2'd0,
		PHASE_UP   = 2'd1,
		PHASE_MOVE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [RAW_W-1:0]   raw_x;
		logic [RAW_W-1:0]   raw_y;
		logic [STAMP_W-1:0] stamp;
		phase_t             phase;
	} sample_job_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
		logic             flip_x;
		logic             flip_y;
	} axis_cfg_t;

endpackage

// ===== rtl/core/tevd_front.sv =====
// event classifier: slot 0 tracking state and sample jobs on sync reports
module tevd_front import tevd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [15:0] event_type,
	input  logic [15:0] event_code,
	input  logic [31:0] event_value,
	input  logic [47:0] time_ms,
	output logic        job_push,
	output sample_job_t job
);

	logic             other_slot_q;
	logic             finger_down_q;
	logic             press_q;
	logic             release_q;
	logic             moved_q;
	logic [RAW_W-1:0] raw_x_q;
	logic [RAW_W-1:0] raw_y_q;

	logic   accept;
	logic   is_abs;
	logic   is_sync;
	logic   emit;
	phase_t phase;

	assign accept  = push && !full;
	assign is_abs  = event_type == EV_TYPE_ABS;
	assign is_sync = (event_type == EV_TYPE_SYNC) && (event_code == CODE_REPORT);

	// down wins over up, up over move
	always_comb begin
		emit  = 1'b0;
		phase = PHASE_MOVE;
		if (press_q && !finger_down_q) begin
			emit  = 1'b1;
			phase = PHASE_DOWN;
		end else if (release_q && finger_down_q) begin
			emit  = 1'b1;
			phase = PHASE_UP;
		end else if (moved_q && finger_down_q) begin
			emit  = 1'b1;
		end
	end

	assign job_push  = accept && is_sync && emit;
	assign job.raw_x = raw_x_q;
	assign job.raw_y = raw_y_q;
	assign job.stamp = time_ms;
	assign job.phase = phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			other_slot_q  <= 1'b0;
			finger_down_q <= 1'b0;
			press_q       <= 1'b0;
			release_q     <= 1'b0;
			moved_q       <= 1'b0;
			raw_x_q       <= '0;
			raw_y_q       <= '0;
		end else if (accept) begin
			if (is_abs) begin
				if (event_code == CODE_SLOT) begin
					other_slot_q <= event_value != '0;
				end else if (!other_slot_q) begin
					case (event_code)
						CODE_TRACK: begin
							if (event_value[31]) release_q <= 1'b1;
							else press_q <= 1'b1;
						end
						CODE_POS_X: begin
							raw_x_q <= event_value;
							moved_q <= 1'b1;
						end
						CODE_POS_Y: begin
							raw_y_q <= event_value;
							moved_q <= 1'b1;
						end
						default: ;
					endcase
				end
			end else if (is_sync) begin
				if (emit && phase == PHASE_DOWN) finger_down_q <= 1'b1;
				if (emit && phase == PHASE_UP) finger_down_q <= 1'b0;
				press_q   <= 1'b0;
				release_q <= 1'b0;
				moved_q   <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/tevd_queue.sv =====
// small job queue between the classifier and the normalizer
module tevd_queue import tevd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  sample_job_t wr_data,
	output logic        full,
	input  logic        rd_en,
	output sample_job_t rd_data,
	output logic        empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sample_job_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/tevd_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit FRAC bits
module tevd_div import tevd_pkg::*; #(
	parameter int FRAC = COORD_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAW_W+FRAC:0]   dividend,
	input  logic [RAW_W-1:0]      divisor,
	output logic                  busy,
	output logic [FRAC-1:0]       quotient
);

	localparam int CNT_W = $clog2(FRAC + 1);

	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] dvs_q;
	logic [FRAC-1:0]  dvd_q;
	logic [FRAC-1:0]  quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [RAW_W:0] trial;
	logic [RAW_W:0] diff;
	logic           fits;

	assign trial    = {rem_q, dvd_q[FRAC-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign fits     = trial >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			// upper part is below the divisor when the quotient fits
			rem_q <= dividend[RAW_W+FRAC-1:FRAC];
			dvd_q <= dividend[FRAC-1:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
			dvd_q <= {dvd_q[FRAC-2:0], 1'b0};
			quo_q <= {quo_q[FRAC-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(FRAC);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/tevd_back.sv =====
// normalizer: offsets, range checks, two dividers and the result register
module tevd_back import tevd_pkg::*; #(
	parameter int FRAC = COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  axis_cfg_t          cfg,
	input  logic               job_empty,
	input  sample_job_t        job,
	output logic               job_pop,
	input  logic               pop,
	output logic               empty,
	output logic [POS_W-1:0]   pos_x,
	output logic [POS_W-1:0]   pos_y,
	output logic [STAMP_W-1:0] stamp_ms,
	output logic [1:0]         phase
);

	localparam int DW = RAW_W + FRAC + 1;
	localparam logic [FRAC-1:0] FULL = '1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PREP,
		B_DIV
	} bstate_t;

	bstate_t              state_q;
	logic signed [RAW_W:0] rng_x_q, rng_y_q, num_x_q, num_y_q;
	logic [STAMP_W-1:0]   stamp_q;
	phase_t               phase_q;
	logic                 bad_x_q, bad_y_q, lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     pos_x_q, pos_y_q;
	logic [STAMP_W-1:0]   out_stamp_q;
	phase_t               out_phase_q;

	logic signed [RAW_W:0] rng_x, rng_y, num_x, num_y;
	logic [DW-1:0]         dvd_x, dvd_y;
	logic                  start;
	logic                  busy_x, busy_y;
	logic [FRAC-1:0]       quo_x, quo_y;
	logic [FRAC-1:0]       q_x, q_y, f_x, f_y;
	logic                  slot_free;
	logic                  load;

	// exact 33-bit differences of sign-extended values
	assign rng_x = $signed({cfg.x_max[RAW_W-1], cfg.x_max}) - $signed({cfg.x_min[RAW_W-1], cfg.x_min});
	assign rng_y = $signed({cfg.y_max[RAW_W-1], cfg.y_max}) - $signed({cfg.y_min[RAW_W-1], cfg.y_min});
	assign num_x = $signed({job.raw_x[RAW_W-1], job.raw_x}) - $signed({cfg.x_min[RAW_W-1], cfg.x_min});
	assign num_y = $signed({job.raw_y[RAW_W-1], job.raw_y}) - $signed({cfg.y_min[RAW_W-1], cfg.y_min});

	// num * FULL + range / 2, with num * FULL as a shift and a subtract
	assign dvd_x = {1'b0, num_x_q[RAW_W-1:0], {FRAC{1'b0}}} - DW'(num_x_q[RAW_W-1:0])
		+ DW'(rng_x_q[RAW_W:1]);
	assign dvd_y = {1'b0, num_y_q[RAW_W-1:0], {FRAC{1'b0}}} - DW'(num_y_q[RAW_W-1:0])
		+ DW'(rng_y_q[RAW_W:1]);

	assign start     = state_q == B_PREP;
	assign job_pop   = (state_q == B_IDLE) && !job_empty;
	assign slot_free = !out_valid_q || pop;
	assign load      = (state_q == B_DIV) && !busy_x && !busy_y && slot_free;

	tevd_div #(.FRAC(FRAC)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (dvd_x),
		.divisor  (rng_x_q[RAW_W-1:0]),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	tevd_div #(.FRAC(FRAC)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (dvd_y),
		.divisor  (rng_y_q[RAW_W-1:0]),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	// clamps override the divider, an empty range gives zero even when flipped
	always_comb begin
		q_x = lo_x_q ? '0 : (hi_x_q ? FULL : quo_x);
		q_y = lo_y_q ? '0 : (hi_y_q ? FULL : quo_y);
		f_x = bad_x_q ? '0 : (cfg.flip_x ? FULL - q_x : q_x);
		f_y = bad_y_q ? '0 : (cfg.flip_y ? FULL - q_y : q_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			rng_x_q     <= '0;
			rng_y_q     <= '0;
			num_x_q     <= '0;
			num_y_q     <= '0;
			stamp_q     <= '0;
			phase_q     <= PHASE_MOVE;
			bad_x_q     <= 1'b0;
			bad_y_q     <= 1'b0;
			lo_x_q      <= 1'b0;
			lo_y_q      <= 1'b0;
			hi_x_q      <= 1'b0;
			hi_y_q      <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_stamp_q <= '0;
			out_phase_q <= PHASE_MOVE;
		end else begin
			// a new sample replaces the one leaving in the same cycle
			if (load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						rng_x_q <= rng_x;
						rng_y_q <= rng_y;
						num_x_q <= num_x;
						num_y_q <= num_y;
						stamp_q <= job.stamp;
						phase_q <= job.phase;
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					bad_x_q <= rng_x_q[RAW_W] || (rng_x_q == '0);
					bad_y_q <= rng_y_q[RAW_W] || (rng_y_q == '0);
					lo_x_q  <= num_x_q[RAW_W] || (num_x_q == '0);
					lo_y_q  <= num_y_q[RAW_W] || (num_y_q == '0);
					hi_x_q  <= num_x_q >= rng_x_q;
					hi_y_q  <= num_y_q >= rng_y_q;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (load) begin
						pos_x_q     <= POS_W'(f_x);
						pos_y_q     <= POS_W'(f_y);
						out_stamp_q <= stamp_q;
						out_phase_q <= phase_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign empty    = !out_valid_q;
	assign pos_x    = pos_x_q;
	assign pos_y    = pos_y_q;
	assign stamp_ms = out_stamp_q;
	assign phase    = out_phase_q;

endmodule

// ===== rtl/core/touch_event_to_sample_decoder.sv =====
// top level of the touch event decoder: registers, classifier, job queue, normalizer
//
// Input channel: one event beat (event_type, event_code, event_value, time_ms)
// is taken at each clock edge with push high and full low. Events are
// classified in the cycle they arrive, so the input runs at one beat per
// cycle while full stays low.
// A sync report that yields a sample places a job in a job queue
// (QUEUE_DEPTH entries); full rises when that queue is full and then holds off
// every event beat until the normalizer takes a job.
// The normalizer works on one sample at a time: it registers the offsets, then
// the range checks and the scaled dividend, then forms one quotient bit per
// cycle in two restoring dividers running side by side.
// Result channel: the oldest sample sits on pos_x, pos_y, stamp_ms and phase
// while empty is low and leaves at an edge with pop high. A stalled receiver
// holds the sample in the result register, the normalizer then waits with its
// finished job, and the queue fills behind it.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// indexes beyond flip_y are ignored. Writes belong to idle periods.
// Reset clears the tracking state, the queue and the result register; the
// range registers return to 0..4095 with no mirroring.
module touch_event_to_sample_decoder import tevd_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [15:0]          event_type,
	input  logic [15:0]          event_code,
	input  logic [31:0]          event_value,
	input  logic [STAMP_W-1:0]   time_ms,
	output logic                 empty,
	input  logic                 pop,
	output logic [POS_W-1:0]     pos_x,
	output logic [POS_W-1:0]     pos_y,
	output logic [STAMP_W-1:0]   stamp_ms,
	output logic [1:0]           phase,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RAW_W-1:0]     cfg_data
);

	axis_cfg_t   cfg_q;
	logic        job_push;
	sample_job_t job_in;
	sample_job_t job_out;
	logic        job_empty;
	logic        job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min  <= 32'sd0;
			cfg_q.x_max  <= 32'sd4095;
			cfg_q.y_min  <= 32'sd0;
			cfg_q.y_max  <= 32'sd4095;
			cfg_q.flip_x <= 1'b0;
			cfg_q.flip_y <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_MIN:  cfg_q.x_min  <= cfg_data;
				REG_X_MAX:  cfg_q.x_max  <= cfg_data;
				REG_Y_MIN:  cfg_q.y_min  <= cfg_data;
				REG_Y_MAX:  cfg_q.y_max  <= cfg_data;
				REG_FLIP_X: cfg_q.flip_x <= cfg_data[0];
				REG_FLIP_Y: cfg_q.flip_y <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tevd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.event_type  (event_type),
		.event_code  (event_code),
		.event_value (event_value),
		.time_ms     (time_ms),
		.job_push    (job_push),
		.job         (job_in)
	);

	tevd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.full    (full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	tevd_back #(.FRAC(COORD_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.stamp_ms  (stamp_ms),
		.phase     (phase)
	);

endmodule

// ===== rtl/core/tevd_checker.sv =====
// port-level checks for the touch event decoder, bound to the top level
module tevd_checker import tevd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [15:0]        event_type,
	input logic [15:0]        event_code,
	input logic               empty,
	input logic               pop,
	input logic [POS_W-1:0]   pos_x,
	input logic [POS_W-1:0]   pos_y,
	input logic [STAMP_W-1:0] stamp_ms,
	input logic [1:0]         phase
);

	// a waiting sample stays put until its beat is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pos_x) && $stable(pos_y)
			&& $stable(stamp_ms) && $stable(phase))
		else $error("result changed while stalled");

	// only down, up and move come out
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> phase == PHASE_DOWN || phase == PHASE_UP || phase == PHASE_MOVE)
		else $error("illegal phase on result");

	// the job queue only fills on an accepted sync report
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && event_type == EV_TYPE_SYNC
			&& event_code == CODE_REPORT))
		else $error("full rose without a sync beat");

endmodule

bind touch_event_to_sample_decoder tevd_checker u_tevd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.event_type (event_type),
	.event_code (event_code),
	.empty      (empty),
	.pop        (pop),
	.pos_x      (pos_x),
	.pos_y      (pos_y),
	.stamp_ms   (stamp_ms),
	.phase      (phase)
);

// ===== dv/touch_event_to_sample_decoder_test.sv =====
// testbench for the touch event decoder: predicting scoreboard, event and sample queue drivers
module touch_event_to_sample_decoder_test;
	import tevd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam longint FULL_SCALE = (longint'(1) << COORD_FRAC_BITS_DEF) - 1;
	localparam logic [31:0] TRACK_LIFT = 32'hffff_ffff;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

	typedef struct {
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [STAMP_W-1:0] stamp;
		phase_t             ph;
	} sample_t;

	class sample_scoreboard;
		logic [RAW_W-1:0] x_min, x_max, y_min, y_max;
		bit flip_x, flip_y;
		bit other_slot, finger_down, press_pending, release_pending, moved_pending;
		logic [RAW_W-1:0] raw_x, raw_y;
		sample_t expected[$];
		int errors;

		function new();
			x_min = '0;
			x_max = 32'd4095;
			y_min = '0;
			y_max = 32'd4095;
			flip_x = 0;
			flip_y = 0;
			other_slot = 0;
			finger_down = 0;
			press_pending = 0;
			release_pending = 0;
			moved_pending = 0;
			raw_x = '0;
			raw_y = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
			case (idx)
				REG_X_MIN:  x_min = data;
				REG_X_MAX:  x_max = data;
				REG_Y_MIN:  y_min = data;
				REG_Y_MAX:  y_max = data;
				REG_FLIP_X: flip_x = data[0];
				REG_FLIP_Y: flip_y = data[0];
				default: ;
			endcase
		endfunction

		function logic [POS_W-1:0] scale_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
				logic [RAW_W-1:0] hi, bit flip);
			longint span, num, q;
			span = longint'($signed(hi)) - longint'($signed(lo));
			num = longint'($signed(raw)) - longint'($signed(lo));
			if (span <= 0)
				return '0;
			if (num <= 0)
				q = 0;
			else if (num >= span)
				q = FULL_SCALE;
			else
				q = (num * FULL_SCALE + span / 2) / span;
			if (flip)
				q = FULL_SCALE - q;
			return q[POS_W-1:0];
		endfunction

		function void note_event(logic [15:0] ev_type, logic [15:0] code, logic [31:0] value,
				logic [STAMP_W-1:0] stamp);
			bit emit;
			sample_t s;
			if (ev_type == EV_TYPE_ABS) begin
				if (code == CODE_SLOT)
					other_slot = (value != 0);
				else if (!other_slot) begin
					case (code)
						CODE_TRACK: begin
							if (value[31])
								release_pending = 1;
							else
								press_pending = 1;
						end
						CODE_POS_X: begin
							raw_x = value;
							moved_pending = 1;
						end
						CODE_POS_Y: begin
							raw_y = value;
							moved_pending = 1;
						end
						default: ;
					endcase
				end
			end else if (ev_type == EV_TYPE_SYNC && code == CODE_REPORT) begin
				emit = 1;
				s.ph = PHASE_MOVE;
				if (press_pending && !finger_down) begin
					finger_down = 1;
					s.ph = PHASE_DOWN;
				end else if (release_pending && finger_down) begin
					finger_down = 0;
					s.ph = PHASE_UP;
				end else if (!(moved_pending && finger_down))
					emit = 0;
				press_pending = 0;
				release_pending = 0;
				moved_pending = 0;
				if (emit) begin
					s.x = scale_axis(raw_x, x_min, x_max, flip_x);
					s.y = scale_axis(raw_y, y_min, y_max, flip_y);
					s.stamp = stamp;
					expected.push_back(s);
				end
			end
		endfunction

		task report(string msg);
			if (errors < 30)
				$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_sample(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [STAMP_W-1:0] stamp,
				logic [1:0] ph);
			sample_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected sample x=%0d y=%0d stamp=%0h phase=%0d",
					x, y, stamp, ph));
				return;
			end
			want = expected.pop_front();
			if (x !== want.x)
				report($sformatf("pos_x got %0d want %0d", x, want.x));
			if (y !== want.y)
				report($sformatf("pos_y got %0d want %0d", y, want.y));
			if (stamp !== want.stamp)
				report($sformatf("stamp_ms got %0h want %0h", stamp, want.stamp));
			if (ph !== want.ph)
				report($sformatf("phase got %0d want %0d", ph, want.ph));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push;
	logic                 full;
	logic [15:0]          event_type;
	logic [15:0]          event_code;
	logic [31:0]          event_value;
	logic [STAMP_W-1:0]   time_ms;
	logic                 empty;
	logic                 pop;
	logic [POS_W-1:0]     pos_x;
	logic [POS_W-1:0]     pos_y;
	logic [STAMP_W-1:0]   stamp_ms;
	logic [1:0]           phase;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RAW_W-1:0]     cfg_data;

	sample_scoreboard sb = new();
	bit send_idle_en = 1;
	bit recv_idle_en = 1;
	int hold_request = 0;
	int items_sent = 0;

	touch_event_to_sample_decoder u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(4000000);
		$display("** touch_event_to_sample_decoder: FAILED **");
		$finish;
	end

	task send_event(logic [15:0] ev_type, logic [15:0] code, logic [31:0] value,
			logic [STAMP_W-1:0] stamp);
		event_type <= ev_type;
		event_code <= code;
		event_value <= value;
		time_ms <= stamp;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_event(ev_type, code, value, stamp);
		if (send_idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task ev(logic [15:0] ev_type, logic [15:0] code, logic [31:0] value);
		send_event(ev_type, code, value, STAMP_W'({$urandom, $urandom}));
		items_sent++;
	endtask

	function logic [31:0] rand_coord(logic [31:0] lo, logic [31:0] hi);
		longint span;
		longint unsigned r;
		span = longint'($signed(hi)) - longint'($signed(lo));
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return lo - 1;
			3: return hi + 1;
			4: return $urandom;
			default: begin
				if (span <= 0)
					return $urandom;
				return lo + 32'(r % longint'(span + 1));
			end
		endcase
	endfunction

	// one finger: press, a few reports with moves, optional lift; pieces dropped at random
	task one_touch();
		int n;
		if ($urandom_range(0, 1))
			ev(EV_TYPE_ABS, CODE_SLOT, 32'd0);
		if ($urandom_range(0, 7) != 0)
			ev(EV_TYPE_ABS, CODE_TRACK, $urandom & INT_MAX);
		if ($urandom_range(0, 3) != 0)
			ev(EV_TYPE_ABS, CODE_POS_X, rand_coord(sb.x_min, sb.x_max));
		if ($urandom_range(0, 3) != 0)
			ev(EV_TYPE_ABS, CODE_POS_Y, rand_coord(sb.y_min, sb.y_max));
		ev(EV_TYPE_SYNC, CODE_REPORT, $urandom);
		n = $urandom_range(0, 6);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: ev(EV_TYPE_ABS, CODE_POS_X, rand_coord(sb.x_min, sb.x_max));
				1: ev(EV_TYPE_ABS, CODE_POS_Y, rand_coord(sb.y_min, sb.y_max));
				2: ; // report with nothing pending
				3: begin
					// another finger: its axis events must not leak into slot 0
					ev(EV_TYPE_ABS, CODE_SLOT, $urandom_range(0, 1) ? $urandom | 32'd1 : 32'd1);
					ev(EV_TYPE_ABS, CODE_POS_X, $urandom);
					ev(EV_TYPE_ABS, CODE_TRACK, $urandom);
					if ($urandom_range(0, 3) != 0)
						ev(EV_TYPE_ABS, CODE_SLOT, 32'd0);
				end
				default: begin
					ev(EV_TYPE_ABS, CODE_POS_X, rand_coord(sb.x_min, sb.x_max));
					ev(EV_TYPE_ABS, CODE_POS_Y, rand_coord(sb.y_min, sb.y_max));
				end
			endcase
			ev(EV_TYPE_SYNC, CODE_REPORT, $urandom);
		end
		if ($urandom_range(0, 5) != 0) begin
			ev(EV_TYPE_ABS, CODE_TRACK, $urandom | INT_MIN);
			if ($urandom_range(0, 1))
				ev(EV_TYPE_ABS, CODE_POS_X, rand_coord(sb.x_min, sb.x_max));
			ev(EV_TYPE_SYNC, CODE_REPORT, $urandom);
		end
	endtask

	task run_touch(int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(0, 7) == 0) begin
				// junk events, mostly of unknown type or code
				repeat ($urandom_range(1, 3))
					send_event(16'($urandom), 16'($urandom), $urandom,
						STAMP_W'({$urandom, $urandom}));
			end else
				one_touch();
		end
	endtask

	task drain();
		push <= 1'b0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task configure(logic [31:0] xlo, logic [31:0] xhi, logic [31:0] ylo, logic [31:0] yhi,
			bit fx, bit fy);
		drain();
		write_reg(REG_X_MIN, xlo);
		write_reg(REG_X_MAX, xhi);
		write_reg(REG_Y_MIN, ylo);
		write_reg(REG_Y_MAX, yhi);
		write_reg(REG_FLIP_X, ($urandom & ~32'd1) | fx);
		write_reg(REG_FLIP_Y, ($urandom & ~32'd1) | fy);
		write_reg(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_side
		int gap_left, hold_left;
		gap_left = 0;
		hold_left = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_sample(pos_x, pos_y, stamp_ms, phase);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				pop <= 1'b0;
			end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 4) - 1;
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	initial begin : stimulus
		logic [31:0] lo_x, lo_y;
		push <= 1'b0;
		event_type <= '0;
		event_code <= '0;
		event_value <= '0;
		time_ms <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, on the reset ranges 0..4095
		ev(EV_TYPE_ABS, CODE_SLOT, 32'd0);
		ev(EV_TYPE_ABS, CODE_TRACK, 32'd5);
		ev(EV_TYPE_ABS, CODE_POS_X, 32'd0);
		ev(EV_TYPE_ABS, CODE_POS_Y, 32'd4095);
		send_event(EV_TYPE_SYNC, CODE_REPORT, 32'd0, {STAMP_W{1'b1}});
		ev(EV_TYPE_ABS, CODE_POS_X, 32'd2048);
		send_event(EV_TYPE_SYNC, CODE_REPORT, 32'd0, '0);
		ev(EV_TYPE_ABS, CODE_POS_X, INT_MIN);
		ev(EV_TYPE_ABS, CODE_POS_Y, INT_MAX);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		// press while already down gives nothing
		ev(EV_TYPE_ABS, CODE_TRACK, 32'd7);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		ev(EV_TYPE_ABS, CODE_SLOT, 32'd3);
		ev(EV_TYPE_ABS, CODE_POS_X, 32'd1000);
		ev(EV_TYPE_ABS, CODE_TRACK, TRACK_LIFT);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		ev(EV_TYPE_ABS, CODE_SLOT, 32'd0);
		ev(16'hffff, CODE_POS_X, 32'd5);
		ev(EV_TYPE_ABS, 16'hffff, 32'd5);
		ev(EV_TYPE_SYNC, 16'h0001, 32'd0);
		ev(EV_TYPE_ABS, CODE_TRACK, TRACK_LIFT);
		ev(EV_TYPE_ABS, CODE_POS_X, 32'd4095);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		// move while up gives nothing; press and lift in one report gives down
		ev(EV_TYPE_ABS, CODE_POS_X, 32'd100);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);
		ev(EV_TYPE_ABS, CODE_TRACK, 32'd0);
		ev(EV_TYPE_ABS, CODE_TRACK, 32'hffff_fffb);
		ev(EV_TYPE_SYNC, CODE_REPORT, 32'd0);

		run_touch(150);

		configure(INT_MIN, INT_MAX, 32'd0, 32'd4095, 1, 0);
		run_touch(90);
		// receiver stalls while a finger keeps moving, so the job queue backs up
		hold_request = 150;
		ev(EV_TYPE_ABS, CODE_SLOT, 32'd0);
		ev(EV_TYPE_ABS, CODE_TRACK, 32'd1);
		repeat (20) begin
			ev(EV_TYPE_ABS, CODE_POS_X, rand_coord(sb.x_min, sb.x_max));
			ev(EV_TYPE_SYNC, CODE_REPORT, $urandom);
		end
		run_touch(90);

		// zero and negative ranges
		configure(32'd100, 32'd100, 32'd500, -32'sd500, 1, 1);
		run_touch(120);

		configure(-32'sd1000, 32'd1000, 32'd7, 32'd8, 0, 1);
		run_touch(120);
		drain();
		run_touch(80);

		configure(INT_MAX, INT_MIN, INT_MIN, INT_MAX, 0, 0);
		run_touch(120);

		lo_x = $urandom;
		lo_y = $urandom;
		configure(lo_x, lo_x + $urandom_range(1, 100000), lo_y, lo_y + $urandom_range(1, 5000),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		run_touch(200);

		send_idle_en = 0;
		recv_idle_en = 0;
		configure(-32'sd2048, 32'd2047, 32'd0, 32'd65535, 1, 1);
		run_touch(200);

		drain();
		if (sb.errors == 0)
			$display("** touch_event_to_sample_decoder: PASSED **");
		else
			$display("** touch_event_to_sample_decoder: FAILED **");
		$finish;
	end

endmodule
